// ----- rtl/hsv_to_rgb_pixel_macros.svh -----
// ---------------------------------------------------------------------------
// HSV to RGB pixel converter assertion macros
// Concurrent checks clocked on clock; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PIXEL_MACROS_SVH
`define HSV_TO_RGB_PIXEL_MACROS_SVH

`ifndef SYNTH
// Check outside reset.
`define HSVP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hsv_to_rgb_pixel assertion failed");
// Check on every edge, reset included.
`define HSVP_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("hsv_to_rgb_pixel assertion failed");
`else
`define HSVP_ASSERT(label, prop)
`define HSVP_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- rtl/hsvp_pkg.sv -----
// ---------------------------------------------------------------------------
// HSV to RGB pixel package
// Beat types, sector codes, constants and constant-divide helpers.
// ---------------------------------------------------------------------------
package hsvp_pkg;

   localparam logic [7:0] HUE_TOP     = 8'd254;
   localparam logic [7:0] SECTOR_SPAN = 8'd85;
   localparam logic [6:0] RAMP_PEAK   = 7'd42;
   localparam logic [7:0] EDGE1       = 8'd42;
   localparam logic [7:0] EDGE2       = 8'd84;
   localparam logic [7:0] EDGE3       = 8'd127;
   localparam logic [7:0] EDGE4       = 8'd169;
   localparam logic [7:0] EDGE5       = 8'd212;

   // floor(ramp / 10710) == (ramp * RAMP_RECIP) >> RAMP_SHIFT for ramp <= 42*255*255
   localparam logic [21:0] RAMP_RECIP = 22'd3208193;
   localparam int          RAMP_SHIFT = 35;

   typedef struct packed {
      logic [7:0] hue;
      logic [4:0] saturation;
      logic [4:0] brightness;
      logic [7:0] alpha_in;
   } hsv_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha_out;
   } rgb_rsp_type;

   typedef enum logic [2:0] {
      SEC_RED_UP    = 3'd0,
      SEC_GREEN_TOP = 3'd1,
      SEC_BLUE_UP   = 3'd2,
      SEC_BLUE_TOP  = 3'd3,
      SEC_RED_BACK  = 3'd4,
      SEC_RED_TOP   = 3'd5
   } sector_type;

   // Final-stage terms handed to the channel mux
   typedef struct packed {
      logic       valid;
      sector_type sector;
      logic [7:0] c;
      logic [7:0] m;
      logic [7:0] x;
      logic [7:0] alpha;
   } hsvp_terms_type;

   function automatic logic [7:0] widen5(input logic [4:0] val);
      return {val, val[4:2]};
   endfunction

   // Exact floor(val / 255) for any 16-bit val up to 255*255
   function automatic logic [7:0] div255(input logic [15:0] val);
      logic [16:0] sum;
      sum = {1'b0, val} + {9'b0, val[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

// ----- rtl/hsvp_sector_mux.sv -----
// ---------------------------------------------------------------------------
// HSV to RGB sector mux
// Routes c+m, x+m and m to the channels by hue sector; output register.
// ---------------------------------------------------------------------------
module hsvp_sector_mux
   import hsvp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  hsvp_terms_type terms,
   output logic           rsp_valid,
   output rgb_rsp_type    rsp_data
);

   logic        valid_ff;
   rgb_rsp_type data_ff;
   rgb_rsp_type data_in;
   logic [7:0]  cm;
   logic [7:0]  xm;

   always_comb begin
      cm = terms.c + terms.m;
      xm = terms.x + terms.m;
      data_in.alpha_out = terms.alpha;
      unique case (terms.sector)
         SEC_RED_UP: begin
            data_in.red = cm; data_in.green = xm; data_in.blue = terms.m;
         end
         SEC_GREEN_TOP: begin
            data_in.red = xm; data_in.green = cm; data_in.blue = terms.m;
         end
         SEC_BLUE_UP: begin
            data_in.red = terms.m; data_in.green = cm; data_in.blue = xm;
         end
         SEC_BLUE_TOP: begin
            data_in.red = terms.m; data_in.green = xm; data_in.blue = cm;
         end
         SEC_RED_BACK: begin
            data_in.red = xm; data_in.green = terms.m; data_in.blue = cm;
         end
         default: begin
            data_in.red = cm; data_in.green = terms.m; data_in.blue = xm;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= terms.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- rtl/hsv_to_rgb_pixel.sv -----
// ---------------------------------------------------------------------------
// HSV to RGB pixel converter
// Five-stage pipeline: decode, chroma, ramp/offset, constant divide, mux.
// ---------------------------------------------------------------------------
// Takes one pixel per clock: busy is always low, so every start beat is taken.
// Each result appears on rsp_data with rsp_valid high for one cycle, once it
// has passed the stage 1 to 4 registers and the mux output register, in order;
// the receiver must take it then. Stage 4 holds the 22x22 reciprocal multiply
// that divides the ramp term by 10710.
module hsv_to_rgb_pixel
   import hsvp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  hsv_req_type req_data,
   output logic        rsp_valid,
   output rgb_rsp_type rsp_data
);

   `include "hsv_to_rgb_pixel_macros.svh"

   logic accept;

   // Stage 1: clamp hue, widen, sector and ramp coefficient
   logic [7:0]  hue_c;
   logic [6:0]  pos;
   logic        s1_valid_ff;
   logic [7:0]  s1_sat_ff,   s1_sat_in;
   logic [7:0]  s1_val_ff,   s1_val_in;
   logic [5:0]  s1_k_ff,     s1_k_in;
   sector_type  s1_sec_ff,   s1_sec_in;
   logic [7:0]  s1_alpha_ff;

   // Stage 2: chroma
   logic        s2_valid_ff;
   logic [15:0] s2_chroma_ff, s2_chroma_in;
   logic [7:0]  s2_val_ff;
   logic [5:0]  s2_k_ff;
   sector_type  s2_sec_ff;
   logic [7:0]  s2_alpha_ff;

   // Stage 3: ramp, offset, c
   logic        s3_valid_ff;
   logic [21:0] s3_ramp_ff, s3_ramp_in;
   logic [15:0] s3_offs_ff, s3_offs_in;
   logic [7:0]  s3_c_ff;
   sector_type  s3_sec_ff;
   logic [7:0]  s3_alpha_ff;
   logic [15:0] val255;

   // Stage 4: x and m
   logic        s4_valid_ff;
   logic [7:0]  s4_x_ff, s4_x_in;
   logic [7:0]  s4_m_ff;
   logic [7:0]  s4_c_ff;
   sector_type  s4_sec_ff;
   logic [7:0]  s4_alpha_ff;
   logic [43:0] xprod;

   hsvp_terms_type terms;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      hue_c = (req_data.hue == 8'hFF) ? HUE_TOP : req_data.hue;
      if (hue_c < SECTOR_SPAN) begin
         pos = hue_c[6:0];
      end else if (hue_c < {SECTOR_SPAN[6:0], 1'b0}) begin
         pos = 7'(hue_c - SECTOR_SPAN);
      end else begin
         pos = 7'(hue_c - {SECTOR_SPAN[6:0], 1'b0});
      end
      // 42 - |pos - 42|
      if (pos >= RAMP_PEAK) begin
         s1_k_in = 6'({RAMP_PEAK[5:0], 1'b0} - pos);
      end else begin
         s1_k_in = pos[5:0];
      end
      if (hue_c < EDGE1) begin
         s1_sec_in = SEC_RED_UP;
      end else if (hue_c < EDGE2) begin
         s1_sec_in = SEC_GREEN_TOP;
      end else if (hue_c < EDGE3) begin
         s1_sec_in = SEC_BLUE_UP;
      end else if (hue_c < EDGE4) begin
         s1_sec_in = SEC_BLUE_TOP;
      end else if (hue_c < EDGE5) begin
         s1_sec_in = SEC_RED_BACK;
      end else begin
         s1_sec_in = SEC_RED_TOP;
      end
      s1_sat_in = widen5(req_data.saturation);
      s1_val_in = widen5(req_data.brightness);
   end

   assign s2_chroma_in = 16'(s1_val_ff) * 16'(s1_sat_ff);

   assign val255     = {s2_val_ff, 8'b0} - {8'b0, s2_val_ff};
   assign s3_offs_in = val255 - s2_chroma_ff;
   assign s3_ramp_in = 22'(s2_k_ff) * 22'(s2_chroma_ff);

   assign xprod   = {22'b0, s3_ramp_ff} * {22'b0, RAMP_RECIP};
   assign s4_x_in = xprod[RAMP_SHIFT +: 8];

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Payload advances every cycle
   always_ff @(posedge clock) begin
      s1_sat_ff    <= s1_sat_in;
      s1_val_ff    <= s1_val_in;
      s1_k_ff      <= s1_k_in;
      s1_sec_ff    <= s1_sec_in;
      s1_alpha_ff  <= req_data.alpha_in;

      s2_chroma_ff <= s2_chroma_in;
      s2_val_ff    <= s1_val_ff;
      s2_k_ff      <= s1_k_ff;
      s2_sec_ff    <= s1_sec_ff;
      s2_alpha_ff  <= s1_alpha_ff;

      s3_ramp_ff   <= s3_ramp_in;
      s3_offs_ff   <= s3_offs_in;
      s3_c_ff      <= div255(s2_chroma_ff);
      s3_sec_ff    <= s2_sec_ff;
      s3_alpha_ff  <= s2_alpha_ff;

      s4_x_ff      <= s4_x_in;
      s4_m_ff      <= div255(s3_offs_ff);
      s4_c_ff      <= s3_c_ff;
      s4_sec_ff    <= s3_sec_ff;
      s4_alpha_ff  <= s3_alpha_ff;
   end

   always_comb begin
      terms.valid  = s4_valid_ff;
      terms.sector = s4_sec_ff;
      terms.c      = s4_c_ff;
      terms.m      = s4_m_ff;
      terms.x      = s4_x_ff;
      terms.alpha  = s4_alpha_ff;
   end

   hsvp_sector_mux u_mux (
      .clock     (clock),
      .reset     (reset),
      .terms     (terms),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `HSVP_ASSERT(a_latency, accept |-> ##5 rsp_valid)
   `HSVP_ASSERT(a_no_spurious, rsp_valid |-> $past(accept, 5))
   `HSVP_ASSERT(a_alpha_pass, rsp_valid |-> rsp_data.alpha_out == $past(req_data.alpha_in, 5))
   `HSVP_ASSERT(a_ramp_le_chroma, s4_valid_ff |-> s4_x_ff <= s4_c_ff)
   `HSVP_ASSERT_ALWAYS(a_reset_clears, reset |=> !s1_valid_ff && !rsp_valid)

endmodule
